// ===== rtl/core/gst_pkg.sv =====
// Shared types, codes and defaults for the graph stack traversal block.
package gst_pkg;

   // Field widths fixed by the beat formats
   localparam int VTX_W  = 6;
   localparam int LINK_W = 10;
   localparam int KIND_W = 2;
   localparam int OP_W   = 2;

   // Default sizes
   localparam int MAX_VERTICES_DFLT = 64;
   localparam int MAX_ENTRIES_DFLT  = 512;

   // End-of-list marker
   localparam logic [LINK_W-1:0] NULL_LINK = '1;

   // Request opcodes
   localparam logic [OP_W-1:0] OP_ADD_EDGE = 2'd0;
   localparam logic [OP_W-1:0] OP_TRAVERSE = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR    = 2'd2;

   // Response kinds
   localparam logic [KIND_W-1:0] KIND_STORED  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DROPPED = 2'd1;
   localparam logic [KIND_W-1:0] KIND_VISITED = 2'd2;
   localparam logic [KIND_W-1:0] KIND_CLEARED = 2'd3;

   typedef struct packed {
      logic [OP_W-1:0]  opcode;
      logic [VTX_W-1:0] vertex_a;
      logic [VTX_W-1:0] vertex_b;
   } gst_req_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [VTX_W-1:0]  vertex;
      logic              last;
   } gst_rsp_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EDGE_A,
      ST_EDGE_B,
      ST_HEAD,
      ST_ENTRY,
      ST_POP,
      ST_POP_WAIT,
      ST_FINAL
   } gst_state_type;

   // Sequencer to adjacency store
   typedef struct packed {
      logic              head_rd;
      logic [VTX_W-1:0]  head_rd_vtx;
      logic              head_wr;
      logic [VTX_W-1:0]  head_wr_vtx;
      logic [LINK_W-1:0] head_wr_link;
      logic              head_clr;
      logic              ent_rd;
      logic [LINK_W-1:0] ent_rd_link;
      logic              ent_wr;
      logic [LINK_W-1:0] ent_wr_link;
      logic [VTX_W-1:0]  ent_wr_vtx;
      logic [LINK_W-1:0] ent_wr_nxt;
   } gst_adj_req_type;

   // Adjacency store read data, registered: valid in the cycle after the read
   typedef struct packed {
      logic [LINK_W-1:0] head_link;
      logic [VTX_W-1:0]  ent_vtx;
      logic [LINK_W-1:0] ent_nxt;
   } gst_adj_rsp_type;

endpackage

// ===== rtl/core/gst_adj.sv =====
// Adjacency store: per-vertex list heads with valid bits and the shared entry memory.
module gst_adj #(
   parameter int MAX_VERTICES = gst_pkg::MAX_VERTICES_DFLT,
   parameter int MAX_ENTRIES  = gst_pkg::MAX_ENTRIES_DFLT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  gst_pkg::gst_adj_req_type adj_req,
   output gst_pkg::gst_adj_rsp_type adj_rsp
);
   import gst_pkg::*;

   localparam int VIDX_W = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int EIDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

   logic [LINK_W-1:0]       head_mem [MAX_VERTICES];
   logic [MAX_VERTICES-1:0] head_vld_ff;
   logic [LINK_W-1:0]       head_rd_ff;

   logic [VTX_W-1:0]        ent_vtx_mem [MAX_ENTRIES];
   logic [LINK_W-1:0]       ent_nxt_mem [MAX_ENTRIES];
   logic [VTX_W-1:0]        ent_vtx_rd_ff;
   logic [LINK_W-1:0]       ent_nxt_rd_ff;

   logic [VIDX_W-1:0] head_ra;
   logic [VIDX_W-1:0] head_wa;
   logic [EIDX_W-1:0] ent_ra;
   logic [EIDX_W-1:0] ent_wa;

   assign head_ra = adj_req.head_rd_vtx[VIDX_W-1:0];
   assign head_wa = adj_req.head_wr_vtx[VIDX_W-1:0];
   assign ent_ra  = adj_req.ent_rd_link[EIDX_W-1:0];
   assign ent_wa  = adj_req.ent_wr_link[EIDX_W-1:0];

   // Head valid bits: a head that was never written since clear reads as null
   always_ff @(posedge clock) begin
      if (reset) begin
         head_vld_ff <= '0;
      end else if (adj_req.head_clr) begin
         head_vld_ff <= '0;
      end else if (adj_req.head_wr) begin
         head_vld_ff[head_wa] <= 1'b1;
      end
   end

   // Head memory, registered read (old data on a same-address write)
   always_ff @(posedge clock) begin
      if (adj_req.head_wr) begin
         head_mem[head_wa] <= adj_req.head_wr_link;
      end
      if (adj_req.head_rd) begin
         head_rd_ff <= head_vld_ff[head_ra] ? head_mem[head_ra] : NULL_LINK;
      end
   end

   // Entry memory, registered read
   always_ff @(posedge clock) begin
      if (adj_req.ent_wr) begin
         ent_vtx_mem[ent_wa] <= adj_req.ent_wr_vtx;
         ent_nxt_mem[ent_wa] <= adj_req.ent_wr_nxt;
      end
      if (adj_req.ent_rd) begin
         ent_vtx_rd_ff <= ent_vtx_mem[ent_ra];
         ent_nxt_rd_ff <= ent_nxt_mem[ent_ra];
      end
   end

   assign adj_rsp.head_link = head_rd_ff;
   assign adj_rsp.ent_vtx   = ent_vtx_rd_ff;
   assign adj_rsp.ent_nxt   = ent_nxt_rd_ff;

endmodule

// ===== rtl/core/gst_ctrl.sv =====
// Sequencer: edge insert, clear, and stack-driven list walk with visited marks.
module gst_ctrl #(
   parameter int MAX_VERTICES = gst_pkg::MAX_VERTICES_DFLT,
   parameter int MAX_ENTRIES  = gst_pkg::MAX_ENTRIES_DFLT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  gst_pkg::gst_req_type     req_data,
   output logic                     res_valid,
   input  logic                     res_stall,
   output gst_pkg::gst_rsp_type     res_data,
   output gst_pkg::gst_adj_req_type adj_req,
   input  gst_pkg::gst_adj_rsp_type adj_rsp
);
   import gst_pkg::*;

   localparam int VIDX_W  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int DEPTH_W = $clog2(MAX_VERTICES + 1);

   gst_state_type state_ff, state_in;

   logic [VTX_W-1:0]        a_ff, a_in;
   logic [VTX_W-1:0]        b_ff, b_in;
   logic [LINK_W-1:0]       used_ff, used_in;
   logic [DEPTH_W-1:0]      depth_ff, depth_in;
   logic [MAX_VERTICES-1:0] visited_ff, visited_in;
   logic [KIND_W-1:0]       pend_kind_ff, pend_kind_in;
   logic [VTX_W-1:0]        pend_vtx_ff, pend_vtx_in;

   // Vertex stack memory
   logic [VTX_W-1:0]  stack_mem [MAX_VERTICES];
   logic [VTX_W-1:0]  stack_rd_ff;
   logic              stack_we;
   logic [VIDX_W-1:0] stack_wa;
   logic [VTX_W-1:0]  stack_wd;
   logic              stack_rd;
   logic [VIDX_W-1:0] stack_ra;

   logic [DEPTH_W-1:0] depth_dec;
   logic [VIDX_W-1:0]  nbr_idx;
   logic               nbr_new;
   logic               head_end;
   logic               nxt_end;
   logic               edge_bad;
   logic               start_ok;

   assign depth_dec = depth_ff - DEPTH_W'(1);
   assign nbr_idx   = adj_rsp.ent_vtx[VIDX_W-1:0];
   assign nbr_new   = !visited_ff[nbr_idx];
   assign head_end  = (adj_rsp.head_link == NULL_LINK) ||
                      (32'(adj_rsp.head_link) >= 32'(MAX_ENTRIES));
   assign nxt_end   = (adj_rsp.ent_nxt == NULL_LINK) ||
                      (32'(adj_rsp.ent_nxt) >= 32'(MAX_ENTRIES));
   assign edge_bad  = (32'(req_data.vertex_a) >= 32'(MAX_VERTICES)) ||
                      (32'(req_data.vertex_b) >= 32'(MAX_VERTICES)) ||
                      (32'(used_ff) + 32'd2 > 32'(MAX_ENTRIES));
   assign start_ok  = 32'(req_data.vertex_a) < 32'(MAX_VERTICES);

   assign req_stall = (state_ff != ST_IDLE);

   // State and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         used_ff    <= '0;
         depth_ff   <= '0;
         visited_ff <= '0;
      end else begin
         state_ff   <= state_in;
         used_ff    <= used_in;
         depth_ff   <= depth_in;
         visited_ff <= visited_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      a_ff         <= a_in;
      b_ff         <= b_in;
      pend_kind_ff <= pend_kind_in;
      pend_vtx_ff  <= pend_vtx_in;
   end

   // Stack memory, registered read
   always_ff @(posedge clock) begin
      if (stack_we) begin
         stack_mem[stack_wa] <= stack_wd;
      end
      if (stack_rd) begin
         stack_rd_ff <= stack_mem[stack_ra];
      end
   end

   // Next state and outputs
   always_comb begin
      state_in     = state_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      used_in      = used_ff;
      depth_in     = depth_ff;
      visited_in   = visited_ff;
      pend_kind_in = pend_kind_ff;
      pend_vtx_in  = pend_vtx_ff;
      adj_req      = '0;
      stack_we     = 1'b0;
      stack_wa     = depth_ff[VIDX_W-1:0];
      stack_wd     = adj_rsp.ent_vtx;
      stack_rd     = 1'b0;
      stack_ra     = depth_dec[VIDX_W-1:0];
      res_valid    = 1'b0;
      res_data     = '{kind: pend_kind_ff, vertex: pend_vtx_ff, last: 1'b0};

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               a_in = req_data.vertex_a;
               b_in = req_data.vertex_b;
               unique case (req_data.opcode)
                  OP_ADD_EDGE: begin
                     if (edge_bad) begin
                        pend_kind_in = KIND_DROPPED;
                        pend_vtx_in  = '0;
                        state_in     = ST_FINAL;
                     end else begin
                        adj_req.head_rd     = 1'b1;
                        adj_req.head_rd_vtx = req_data.vertex_a;
                        state_in            = ST_EDGE_A;
                     end
                  end
                  OP_TRAVERSE: begin
                     if (start_ok) begin
                        visited_in = '0;
                        visited_in[req_data.vertex_a[VIDX_W-1:0]] = 1'b1;
                        pend_kind_in        = KIND_VISITED;
                        pend_vtx_in         = req_data.vertex_a;
                        stack_we            = 1'b1;
                        stack_wa            = '0;
                        stack_wd            = req_data.vertex_a;
                        depth_in            = DEPTH_W'(1);
                        adj_req.head_rd     = 1'b1;
                        adj_req.head_rd_vtx = req_data.vertex_a;
                        state_in            = ST_HEAD;
                     end
                  end
                  OP_CLEAR: begin
                     adj_req.head_clr = 1'b1;
                     used_in          = '0;
                     pend_kind_in     = KIND_CLEARED;
                     pend_vtx_in      = '0;
                     state_in         = ST_FINAL;
                  end
                  default: ;
               endcase
            end
         end

         // First entry: b goes at the head of a's list
         ST_EDGE_A: begin
            adj_req.ent_wr       = 1'b1;
            adj_req.ent_wr_link  = used_ff;
            adj_req.ent_wr_vtx   = b_ff;
            adj_req.ent_wr_nxt   = adj_rsp.head_link;
            adj_req.head_wr      = 1'b1;
            adj_req.head_wr_vtx  = a_ff;
            adj_req.head_wr_link = used_ff;
            adj_req.head_rd      = 1'b1;
            adj_req.head_rd_vtx  = b_ff;
            state_in             = ST_EDGE_B;
         end

         // Second entry: a at the head of b's list; self loop sees the new head
         ST_EDGE_B: begin
            adj_req.ent_wr       = 1'b1;
            adj_req.ent_wr_link  = used_ff + LINK_W'(1);
            adj_req.ent_wr_vtx   = a_ff;
            adj_req.ent_wr_nxt   = (a_ff == b_ff) ? used_ff : adj_rsp.head_link;
            adj_req.head_wr      = 1'b1;
            adj_req.head_wr_vtx  = b_ff;
            adj_req.head_wr_link = used_ff + LINK_W'(1);
            used_in              = used_ff + LINK_W'(2);
            pend_kind_in         = KIND_STORED;
            pend_vtx_in          = '0;
            state_in             = ST_FINAL;
         end

         // Head of the list to scan is available
         ST_HEAD: begin
            if (head_end) begin
               state_in = ST_POP;
            end else begin
               adj_req.ent_rd      = 1'b1;
               adj_req.ent_rd_link = adj_rsp.head_link;
               state_in            = ST_ENTRY;
            end
         end

         // One list entry: a new neighbor sends out the held visit beat
         ST_ENTRY: begin
            res_valid = nbr_new;
            if (!nbr_new || !res_stall) begin
               if (nbr_new) begin
                  visited_in[nbr_idx] = 1'b1;
                  pend_kind_in        = KIND_VISITED;
                  pend_vtx_in         = adj_rsp.ent_vtx;
                  stack_we            = 1'b1;
                  depth_in            = depth_ff + DEPTH_W'(1);
               end
               if (nxt_end) begin
                  state_in = ST_POP;
               end else begin
                  adj_req.ent_rd      = 1'b1;
                  adj_req.ent_rd_link = adj_rsp.ent_nxt;
               end
            end
         end

         ST_POP: begin
            if (depth_ff == '0) begin
               state_in = ST_FINAL;
            end else begin
               depth_in = depth_dec;
               stack_rd = 1'b1;
               state_in = ST_POP_WAIT;
            end
         end

         ST_POP_WAIT: begin
            adj_req.head_rd     = 1'b1;
            adj_req.head_rd_vtx = stack_rd_ff;
            state_in            = ST_HEAD;
         end

         // Held beat closes the item
         ST_FINAL: begin
            res_valid     = 1'b1;
            res_data.last = 1'b1;
            if (!res_stall) begin
               state_in = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// ===== rtl/core/graph_stack_traversal.sv =====
// Edge insert: ST_EDGE_A, ST_EDGE_B, ST_FINAL; clear and dropped edge: ST_FINAL only.
// Traverse: adjacency entries are scanned in ST_ENTRY, and each stack pop passes ST_POP,
//   ST_POP_WAIT and ST_HEAD, all through the head, entry and stack memories.
// Throughput: one item at a time; the next item is taken once the last beat is queued.
// Reset: synchronous; list head valid bits, counters and visited marks clear
//   at once, no clearing pass; the entry and stack memories are not reset.
module graph_stack_traversal #(
   parameter int MAX_VERTICES = gst_pkg::MAX_VERTICES_DFLT,
   parameter int MAX_ENTRIES  = gst_pkg::MAX_ENTRIES_DFLT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  gst_pkg::gst_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output gst_pkg::gst_rsp_type rsp_data
);
   import gst_pkg::*;

   gst_adj_req_type adj_req;
   gst_adj_rsp_type adj_rsp;

   logic        res_valid;
   logic        res_stall;
   gst_rsp_type res_data;

   logic        out_vld_ff;
   gst_rsp_type out_ff;

   gst_ctrl #(
      .MAX_VERTICES (MAX_VERTICES),
      .MAX_ENTRIES  (MAX_ENTRIES)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .res_valid (res_valid),
      .res_stall (res_stall),
      .res_data  (res_data),
      .adj_req   (adj_req),
      .adj_rsp   (adj_rsp)
   );

   gst_adj #(
      .MAX_VERTICES (MAX_VERTICES),
      .MAX_ENTRIES  (MAX_ENTRIES)
   ) u_adj (
      .clock   (clock),
      .reset   (reset),
      .adj_req (adj_req),
      .adj_rsp (adj_rsp)
   );

   // Output register: refills in the cycle its beat is taken
   assign res_stall = out_vld_ff && rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (!res_stall) begin
         out_vld_ff <= res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!res_stall && res_valid) begin
         out_ff <= res_data;
      end
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_ff;

endmodule

// ===== rtl/core/gst_chk.sv =====
// Port-level checker for the graph stack traversal block, bound to the top level.
module gst_chk (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input gst_pkg::gst_req_type req_data,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input gst_pkg::gst_rsp_type rsp_data
);
   import gst_pkg::*;

   // A stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response beat changed");

   // Only visit beats carry a vertex
   a_vertex_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.kind != KIND_VISITED) |-> rsp_data.vertex == '0)
      else $error("non-visit beat with nonzero vertex");

   // Store, drop and clear are single-beat items
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.kind != KIND_VISITED) |-> rsp_data.last)
      else $error("single-beat item without last");

   // An accepted edge insert keeps the block busy in the next cycle
   a_edge_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_data.opcode == OP_ADD_EDGE) |=> req_stall)
      else $error("request taken during edge insert");

endmodule

bind graph_stack_traversal gst_chk u_gst_chk (.*);
